// ----- sv/sha256_message_hash_core_macros.svh -----
// Assertion macros used by the checker file.
`ifndef SHA256_MESSAGE_HASH_CORE_MACROS_SVH
`define SHA256_MESSAGE_HASH_CORE_MACROS_SVH

// Assert that an antecedent implies a consequent in the same cycle.
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Assert that an antecedent implies a consequent in the next cycle.
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/sha_pkg.sv -----
// Shared types, constants and functions of the SHA-256 message hash core.
package sha_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUNDS,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic put_byte;    // store input byte at fill position
        logic put_pad;     // store one padding byte at fill position
        logic put_len;     // write the bit length into words 14 and 15
        logic load_work;   // copy chaining hash to working variables
        logic round;       // run one compression round
        logic fold;        // add working variables into chaining hash
        logic restart;     // back to initial hash, fill and length
        logic emit_shift;  // advance the digest output word
    } t_cmd;

    typedef struct packed {
        logic [5:0] fill;
        logic [5:0] round_idx;
        logic       marker_done;
    } t_status;

    localparam logic [7:0]  PAD_MARKER = 8'h80;
    localparam logic [5:0]  LEN_POS    = 6'd56;

    localparam logic [255:0] INIT_HASH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        unique case (t)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ----- sv/sha_intf.sv -----
// Valid/ready stream interfaces for the input bytes and the digest words.
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last_byte;
    modport source (output valid, data_byte, has_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, has_byte, last_byte, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ----- sv/sha_datapath.sv -----
// Datapath: block buffer, message schedule, round logic and chaining hash.
module sha_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sha_pkg::t_cmd      i_cmd,
    input  logic [7:0]         i_byte,
    output sha_pkg::t_status   o_status,
    output logic [31:0]        o_word
);
    logic [31:0] r_w [16];
    logic [31:0] r_v [8];
    logic [31:0] r_h [8];
    logic [5:0]  r_fill;
    logic [63:0] r_len;
    logic [5:0]  r_round;
    logic        r_marker;

    logic [7:0]  s_put;
    logic [3:0]  s_widx;
    logic [1:0]  s_bidx;
    logic [5:0]  s_t;
    logic [31:0] s_w15, s_w2, s_s0, s_s1, s_wnew, s_wt;
    logic [31:0] s_t1, s_t2;

    assign s_put  = i_cmd.put_byte ? i_byte : (r_marker ? 8'h00 : sha_pkg::PAD_MARKER);
    assign s_widx = r_fill[5:2];
    assign s_bidx = r_fill[1:0];
    assign s_t    = r_round;

    always_comb begin
        s_w15 = r_w[4'(s_t + 6'd1)];
        s_w2  = r_w[4'(s_t + 6'd14)];
        s_s0  = sha_pkg::rotr(s_w15, 7) ^ sha_pkg::rotr(s_w15, 18) ^ (s_w15 >> 3);
        s_s1  = sha_pkg::rotr(s_w2, 17) ^ sha_pkg::rotr(s_w2, 19) ^ (s_w2 >> 10);
        s_wnew = r_w[s_t[3:0]] + s_s0 + r_w[4'(s_t + 6'd9)] + s_s1;
        s_wt  = (s_t < 6'd16) ? r_w[s_t[3:0]] : s_wnew;
        s_t1  = r_v[7]
              + (sha_pkg::rotr(r_v[4], 6) ^ sha_pkg::rotr(r_v[4], 11)
                 ^ sha_pkg::rotr(r_v[4], 25))
              + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + sha_pkg::round_k(s_t) + s_wt;
        s_t2  = (sha_pkg::rotr(r_v[0], 2) ^ sha_pkg::rotr(r_v[0], 13)
                 ^ sha_pkg::rotr(r_v[0], 22))
              + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.put_byte || i_cmd.put_pad) begin
            unique case (s_bidx)
                2'd0: r_w[s_widx][31:24] <= s_put;
                2'd1: r_w[s_widx][23:16] <= s_put;
                2'd2: r_w[s_widx][15:8]  <= s_put;
                2'd3: r_w[s_widx][7:0]   <= s_put;
                default: ;
            endcase
        end
        if (i_cmd.put_len) begin
            r_w[14] <= r_len[63:32];
            r_w[15] <= r_len[31:0];
        end
        if (i_cmd.round) begin
            r_w[s_t[3:0]] <= s_wt;
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + s_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= s_t1 + s_t2;
        end
        if (i_cmd.load_work) begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            for (int i = 0; i < 8; i++) r_h[i] <= sha_pkg::INIT_HASH[255 - 32*i -: 32];
            r_fill   <= '0;
            r_len    <= '0;
            r_round  <= '0;
            r_marker <= 1'b0;
        end else begin
            if (i_cmd.put_byte) begin
                r_fill <= r_fill + 6'd1;
                r_len  <= r_len + 64'd8;
            end
            if (i_cmd.put_pad) begin
                r_fill   <= r_fill + 6'd1;
                r_marker <= 1'b1;
            end
            if (i_cmd.round) r_round <= r_round + 6'd1;
            if (i_cmd.fold) begin
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
            end
            // rotate hash left so the next word moves to the head, word 0
            if (i_cmd.emit_shift) begin
                for (int i = 0; i < 7; i++) r_h[i] <= r_h[i+1];
                r_h[7] <= r_h[0];
            end
        end
    end

    assign o_status.fill        = r_fill;
    assign o_status.round_idx   = r_round;
    assign o_status.marker_done = r_marker;
    assign o_word               = r_h[0];
endmodule

// ----- sv/sha_ctrl.sv -----
// Controller: sequences byte intake, padding, rounds and digest output.
module sha_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    sha_in_if.sink           s_in,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [2:0]       o_out_idx,
    input  sha_pkg::t_status i_status,
    output sha_pkg::t_cmd    o_cmd
);
    sha_pkg::t_state r_state, n_state;
    logic            r_final, n_final;
    logic [2:0]      r_idx, n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha_pkg::ST_IDLE;
            r_final <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_final <= n_final;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_final     = r_final;
        n_idx       = r_idx;
        o_cmd       = '0;
        s_in.ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            sha_pkg::ST_IDLE: begin
                s_in.ready = 1'b1;
                if (s_in.valid) begin
                    o_cmd.put_byte = s_in.has_byte;
                    n_final = s_in.last_byte;
                    if (s_in.has_byte && i_status.fill == 6'd63) begin
                        o_cmd.load_work = 1'b1;
                        n_state = sha_pkg::ST_ROUNDS;
                    end else if (s_in.last_byte) begin
                        n_state = sha_pkg::ST_PAD;
                    end
                end
            end
            sha_pkg::ST_PAD: begin
                // write the marker byte, then zero-fill up to the length field, or to block end if past it
                if (!i_status.marker_done || (i_status.fill != sha_pkg::LEN_POS)) begin
                    o_cmd.put_pad = 1'b1;
                    if (i_status.fill == 6'd63) begin
                        o_cmd.load_work = 1'b1;
                        n_state = sha_pkg::ST_ROUNDS;
                    end
                end else begin
                    o_cmd.put_len   = 1'b1;
                    o_cmd.load_work = 1'b1;
                    n_final = 1'b0;
                    n_state = sha_pkg::ST_ROUNDS;
                end
            end
            sha_pkg::ST_ROUNDS: begin
                o_cmd.round = 1'b1;
                if (i_status.round_idx == 6'd63) n_state = sha_pkg::ST_FOLD;
            end
            sha_pkg::ST_FOLD: begin
                o_cmd.fold = 1'b1;
                if (r_final) n_state = sha_pkg::ST_PAD;
                else if (i_status.marker_done) begin
                    n_idx = '0;
                    n_state = sha_pkg::ST_EMIT;
                end else n_state = sha_pkg::ST_IDLE;
            end
            sha_pkg::ST_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.emit_shift = 1'b1;
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        o_cmd.restart = 1'b1;
                        n_state = sha_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = sha_pkg::ST_IDLE;
        endcase
    end

    assign o_out_idx = r_idx;
endmodule

// ----- sv/sha256_message_hash_core.sv -----
// A byte that does not end a block is only stored; a byte that fills a
// block starts a compression (load, 64 rounds of the single round unit, fold).
// A last item pads one byte per cycle, runs one or two compressions,
// then transfers eight digest words, one per cycle when the sink is ready.
// Synchronous active-low reset loads the initial hash and clears length and fill.
module sha256_message_hash_core (
    input  logic   i_clk,
    input  logic   i_rst_n,
    sha_in_if.sink   s_in,
    sha_out_if.source m_out
);
    sha_pkg::t_cmd    s_cmd;
    sha_pkg::t_status s_status;
    logic [31:0]      s_word;
    logic [2:0]       s_idx;

    sha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_in        (s_in),
        .i_out_ready (m_out.ready),
        .o_out_valid (m_out.valid),
        .o_out_idx   (s_idx),
        .i_status    (s_status),
        .o_cmd       (s_cmd)
    );

    sha_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (s_cmd),
        .i_byte   (s_in.data_byte),
        .o_status (s_status),
        .o_word   (s_word)
    );

    assign m_out.digest_word = s_word;
    assign m_out.word_index  = s_idx;
    assign m_out.last_word   = (s_idx == 3'd7);
endmodule

// ----- sv/sha_checker.sv -----
// Port-level checker for the SHA-256 message hash core, bound to the top level.
`include "sha256_message_hash_core_macros.svh"
module sha_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] digest_word,
    input logic [2:0]  word_index,
    input logic        last_word
);
    `SHA_ASSERT_IMP(a_no_in_while_out, i_clk, i_rst_n, out_valid, !in_ready, "input taken during digest")
    `SHA_ASSERT_IMP(a_last_idx, i_clk, i_rst_n, out_valid, last_word == (word_index == 3'd7), "last_word mismatch")
    `SHA_ASSERT_NEXT(a_idx_adv, i_clk, i_rst_n, out_valid && out_ready && !last_word, out_valid && word_index == $past(word_index) + 3'd1, "index did not advance")
    `SHA_ASSERT_NEXT(a_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid && $stable(digest_word), "stalled word changed")
endmodule

bind sha256_message_hash_core sha_checker u_sha_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .in_valid    (s_in.valid),
    .in_ready    (s_in.ready),
    .out_valid   (m_out.valid),
    .out_ready   (m_out.ready),
    .digest_word (m_out.digest_word),
    .word_index  (m_out.word_index),
    .last_word   (m_out.last_word)
);
